// ===== rtl/dprr_pkg.sv =====
// dprr_pkg: field widths shared by the paging block and its channel interfaces,
// and the small helper used by the paging block.
// No dependencies.
package dprr_pkg;

  // payload field widths of the access and result beats
  localparam int unsigned TaskIdW   = 1;
  localparam int unsigned PageNumW  = 8;
  localparam int unsigned VictimW   = 2;
  localparam int unsigned FrameNumW = 2;

  // reduce an 8-bit value into 0..m-1 by restoring subtraction of shifted m
  function automatic logic [7:0] red_mod(input logic [7:0] v, input int unsigned m);
    logic [7:0]  r;
    int unsigned sh;
    r = v;
    for (int k = 7; k >= 0; k--) begin
      sh = m << k;
      if ((sh <= 32'd255) && ({24'd0, r} >= sh)) begin
        r = r - 8'(sh);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/dprr_req_if.sv =====
// dprr_req_if: access channel (valid/ready plus task, page and victim).
// Depends on dprr_pkg for the field widths.
interface dprr_req_if import dprr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TaskIdW-1:0]  task_id;
  logic [PageNumW-1:0] page_number;
  logic [VictimW-1:0]  victim_frame;

  modport source (output valid, output task_id, output page_number,
                  output victim_frame, input ready);
  modport sink   (input valid, input task_id, input page_number,
                  input victim_frame, output ready);
endinterface

// ===== rtl/dprr_rsp_if.sv =====
// dprr_rsp_if: result channel (valid/ready plus frame, hit and eviction info).
// Depends on dprr_pkg for the field widths.
interface dprr_rsp_if import dprr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FrameNumW-1:0] frame_number;
  logic                 hit;
  logic                 evicted;
  logic [TaskIdW-1:0]   evicted_task;
  logic [PageNumW-1:0]  evicted_page;

  modport source (output valid, output frame_number, output hit, output evicted,
                  output evicted_task, output evicted_page, input ready);
  modport sink   (input valid, input frame_number, input hit, input evicted,
                  input evicted_task, input evicted_page, output ready);
endinterface

// ===== rtl/demand_paging_random_replace.sv =====
// demand_paging_random_replace: per-task page tables with random-victim replacement.
// Result beat is registered: idle takes the access and reads both tables, evaluate
//   writes it once the output is free, and an eviction adds the map state; ready is low
//   until idle (old-owner invalidate and new mapping write share one write port).
// Reset: after rst_ni the page table is swept to invalid, one entry a cycle,
//   all TASKS*PAGES entries (512 by default) with ready low; frames start free.
module demand_paging_random_replace
  import dprr_pkg::*;
#(
  parameter int unsigned PAGES  = 256,
  parameter int unsigned FRAMES = 4,
  parameter int unsigned TASKS  = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dprr_req_if.sink   req_i,
  dprr_rsp_if.source rsp_o
);

  localparam int unsigned Depth = TASKS * PAGES;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW    = $clog2(PAGES);
  localparam int unsigned FW    = $clog2(FRAMES);
  localparam int unsigned TW    = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned PmW   = FW + 1;
  localparam int unsigned FoW   = TW + PW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_MAP
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [FW:0]     fill_q, fill_d;
  logic [TW-1:0]   task_q, task_d;
  logic [PW-1:0]   page_q, page_d;
  logic [FW-1:0]   victim_q, victim_d;
  logic [AW-1:0]   idx_q, idx_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic [FrameNumW-1:0] rsp_frame_q, rsp_frame_d;
  logic                 rsp_hit_q, rsp_hit_d;
  logic                 rsp_evict_q, rsp_evict_d;
  logic [TaskIdW-1:0]   rsp_etask_q, rsp_etask_d;
  logic [PageNumW-1:0]  rsp_epage_q, rsp_epage_d;

  logic            req_fire;
  logic [TW-1:0]   task_red;
  logic [PW-1:0]   page_red;
  logic [FW-1:0]   victim_red;
  logic [AW-1:0]   idx_in;

  logic            pm_we;
  logic [AW-1:0]   pm_waddr;
  logic [PmW-1:0]  pm_wdata;
  logic [PmW-1:0]  pm_rdata;
  logic            fo_we;
  logic [FW-1:0]   fo_waddr;
  logic [FoW-1:0]  fo_wdata;
  logic [FoW-1:0]  fo_rdata;

  logic            out_free;
  logic [TW-1:0]   old_task;
  logic [PW-1:0]   old_page;
  logic [AW-1:0]   old_idx;

  // input fields folded into range
  assign task_red   = (TASKS > 1) ? TW'(req_i.task_id) : '0;
  assign page_red   = PW'(red_mod(req_i.page_number, PAGES));
  assign victim_red = FW'(red_mod(8'(req_i.victim_frame), FRAMES));
  assign idx_in     = AW'(AW'(task_red) * AW'(PAGES)) + AW'(page_red);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // owner of the frame picked as victim
  assign old_task = fo_rdata[FoW-1 -: TW];
  assign old_page = fo_rdata[PW-1:0];
  assign old_idx  = AW'(AW'(old_task) * AW'(PAGES)) + AW'(old_page);

  assign out_free = !rsp_valid_q || rsp_o.ready;

  // page table: valid bit plus frame, indexed by task and page
  dprr_ram #(
    .WIDTH (PmW),
    .DEPTH (Depth)
  ) u_page_map (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .re_i    (req_fire),
    .raddr_i (idx_in),
    .rdata_o (pm_rdata)
  );

  // frame table: owner task and page, valid below the fill count
  dprr_ram #(
    .WIDTH (FoW),
    .DEPTH (FRAMES)
  ) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (fo_we),
    .waddr_i (fo_waddr),
    .wdata_i (fo_wdata),
    .re_i    (req_fire),
    .raddr_i (victim_red),
    .rdata_o (fo_rdata)
  );

  // sequencer: clear sweep, then lookup, allocate or evict, write back
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    fill_d      = fill_q;
    task_d      = task_q;
    page_d      = page_q;
    victim_d    = victim_q;
    idx_d       = idx_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_frame_d = rsp_frame_q;
    rsp_hit_d   = rsp_hit_q;
    rsp_evict_d = rsp_evict_q;
    rsp_etask_d = rsp_etask_q;
    rsp_epage_d = rsp_epage_q;
    pm_we       = 1'b0;
    pm_waddr    = idx_q;
    pm_wdata    = '0;
    fo_we       = 1'b0;
    fo_waddr    = victim_q;
    fo_wdata    = {task_q, page_q};

    case (state_q)
      S_CLEAR: begin
        pm_we     = 1'b1;
        pm_waddr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          task_d   = task_red;
          page_d   = page_red;
          victim_d = victim_red;
          idx_d    = idx_in;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_hit_d   = 1'b0;
          rsp_evict_d = 1'b0;
          rsp_etask_d = '0;
          rsp_epage_d = '0;
          state_d     = S_IDLE;
          if (pm_rdata[FW]) begin
            // hit: report the mapped frame
            rsp_hit_d   = 1'b1;
            rsp_frame_d = FrameNumW'(pm_rdata[FW-1:0]);
          end else if (fill_q < (FW + 1)'(FRAMES)) begin
            // free frame: lowest free is the fill count
            pm_we       = 1'b1;
            pm_wdata    = {1'b1, fill_q[FW-1:0]};
            fo_we       = 1'b1;
            fo_waddr    = fill_q[FW-1:0];
            fill_d      = fill_q + 1'b1;
            rsp_frame_d = FrameNumW'(fill_q[FW-1:0]);
          end else begin
            // evict: drop the old owner's mapping, new mapping next cycle
            pm_we       = 1'b1;
            pm_waddr    = old_idx;
            fo_we       = 1'b1;
            rsp_frame_d = FrameNumW'(victim_q);
            rsp_evict_d = 1'b1;
            rsp_etask_d = TaskIdW'(old_task);
            rsp_epage_d = PageNumW'(old_page);
            state_d     = S_MAP;
          end
        end
      end
      S_MAP: begin
        pm_we    = 1'b1;
        pm_wdata = {1'b1, victim_q};
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      fill_q      <= '0;
      task_q      <= '0;
      page_q      <= '0;
      victim_q    <= '0;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_frame_q <= '0;
      rsp_hit_q   <= 1'b0;
      rsp_evict_q <= 1'b0;
      rsp_etask_q <= '0;
      rsp_epage_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      fill_q      <= fill_d;
      task_q      <= task_d;
      page_q      <= page_d;
      victim_q    <= victim_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_frame_q <= rsp_frame_d;
      rsp_hit_q   <= rsp_hit_d;
      rsp_evict_q <= rsp_evict_d;
      rsp_etask_q <= rsp_etask_d;
      rsp_epage_q <= rsp_epage_d;
    end
  end

  // result beat
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.frame_number = rsp_frame_q;
  assign rsp_o.hit          = rsp_hit_q;
  assign rsp_o.evicted      = rsp_evict_q;
  assign rsp_o.evicted_task = rsp_etask_q;
  assign rsp_o.evicted_page = rsp_epage_q;

`ifndef ASSERT_OFF
  // frames are never handed out past the table size
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (FW + 1)'(FRAMES))
    else $error("fill count beyond frame count");

  // eviction only once every frame is taken
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.evicted) |-> (fill_q == (FW + 1)'(FRAMES)))
    else $error("eviction with a free frame left");

  // a hit never carries an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.hit) |-> !rsp_o.evicted)
    else $error("hit reported together with eviction");

  // a taken access always moves the sequencer out of idle
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_EVAL))
    else $error("accepted access not evaluated");
`endif

endmodule

// ===== rtl/dprr_ram.sv =====
// dprr_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module dprr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
